/* rtl/core/utf8sd_pkg.sv */
// shared types and constants for the utf-8 byte stream decoder
// no dependencies
package utf8sd_pkg;

	localparam int unsigned CpWidth = 21;

	localparam logic [CpWidth-1:0] Replacement  = 21'h00FFFD;
	localparam logic [CpWidth-1:0] SurrogateLo  = 21'h00D800;
	localparam logic [CpWidth-1:0] SurrogateHi  = 21'h00DFFF;
	localparam logic [CpWidth-1:0] MaxScalar    = 21'h10FFFF;
	localparam logic [CpWidth-1:0] Min2Byte     = 21'h000080;
	localparam logic [CpWidth-1:0] Min3Byte     = 21'h000800;
	localparam logic [CpWidth-1:0] Min4Byte     = 21'h010000;

	localparam logic [7:0] ContMask  = 8'hC0;
	localparam logic [7:0] ContCode  = 8'h80;
	localparam logic [7:0] ContBits  = 8'h3F;
	localparam logic [7:0] Lead2Mask = 8'hE0;
	localparam logic [7:0] Lead2Code = 8'hC0;
	localparam logic [7:0] Lead3Mask = 8'hF0;
	localparam logic [7:0] Lead3Code = 8'hE0;
	localparam logic [7:0] Lead4Mask = 8'hF8;
	localparam logic [7:0] Lead4Code = 8'hF0;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} byte_beat_t;

	typedef struct packed {
		logic [CpWidth-1:0] code_point;
		logic               last_of_run;
	} cp_beat_t;

	// results of one decoded byte, zero to two
	typedef struct packed {
		logic [1:0] count;
		cp_beat_t   first;
		cp_beat_t   second;
	} dec_res_t;

endpackage

/* rtl/core/utf8sd_decode.sv */
// per-byte decode logic and sequence state for the utf-8 decoder
// depends on utf8sd_pkg
module utf8sd_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  utf8sd_pkg::byte_beat_t beat,
	output utf8sd_pkg::dec_res_t  res
);

	logic [1:0]                      bytes_owed_q;
	logic [1:0]                      sequence_trailing_q;
	logic [utf8sd_pkg::CpWidth-1:0]  partial_value_q;

	logic [1:0]                      owed_d;
	logic [1:0]                      trail_d;
	logic [utf8sd_pkg::CpWidth-1:0]  pv_d;

	logic [7:0]                      b;
	logic                            eot;
	logic                            is_cont;
	logic [utf8sd_pkg::CpWidth-1:0]  pv_shift;
	logic [1:0]                      owed_dec;
	logic [utf8sd_pkg::CpWidth-1:0]  min_val;
	logic                            bad_val;
	logic [utf8sd_pkg::CpWidth-1:0]  checked;
	logic [1:0]                      n;
	logic [utf8sd_pkg::CpWidth-1:0]  cp0;
	logic [utf8sd_pkg::CpWidth-1:0]  cp1;
	logic [utf8sd_pkg::CpWidth-1:0]  lead_cp;
	logic                            lead_emit;

	assign b        = beat.text_byte;
	assign eot      = beat.end_of_text;
	assign is_cont  = (b & utf8sd_pkg::ContMask) == utf8sd_pkg::ContCode;
	assign pv_shift = {partial_value_q[utf8sd_pkg::CpWidth-7:0], 6'b0}
		| {13'b0, b & utf8sd_pkg::ContBits};
	assign owed_dec = bytes_owed_q - 2'd1;

	always_comb begin
		case (sequence_trailing_q)
			2'd1: min_val = utf8sd_pkg::Min2Byte;
			2'd2: min_val = utf8sd_pkg::Min3Byte;
			default: min_val = utf8sd_pkg::Min4Byte;
		endcase
	end

	assign bad_val = (pv_shift < min_val)
		|| ((pv_shift >= utf8sd_pkg::SurrogateLo) && (pv_shift <= utf8sd_pkg::SurrogateHi))
		|| (pv_shift > utf8sd_pkg::MaxScalar);
	assign checked = bad_val ? utf8sd_pkg::Replacement : pv_shift;

	always_comb begin
		owed_d    = bytes_owed_q;
		trail_d   = sequence_trailing_q;
		pv_d      = partial_value_q;
		n         = 2'd0;
		cp0       = utf8sd_pkg::Replacement;
		cp1       = utf8sd_pkg::Replacement;
		lead_cp   = utf8sd_pkg::Replacement;
		lead_emit = 1'b0;
		if ((bytes_owed_q != 2'd0) && is_cont) begin
			pv_d   = pv_shift;
			owed_d = owed_dec;
			if (owed_dec == 2'd0) begin
				n       = 2'd1;
				cp0     = checked;
				owed_d  = 2'd0;
				trail_d = 2'd0;
				pv_d    = '0;
			end else if (eot) begin
				n = 2'd1;
			end
		end else begin
			// lead byte or stray byte, possibly after a cut sequence
			if ((b & 8'h80) == 8'h00) begin
				lead_emit = 1'b1;
				lead_cp   = {13'b0, b};
				owed_d    = 2'd0;
				trail_d   = 2'd0;
				pv_d      = '0;
			end else if ((b & utf8sd_pkg::Lead2Mask) == utf8sd_pkg::Lead2Code) begin
				owed_d    = 2'd1;
				trail_d   = 2'd1;
				pv_d      = {16'b0, b[4:0]};
				lead_emit = eot;
			end else if ((b & utf8sd_pkg::Lead3Mask) == utf8sd_pkg::Lead3Code) begin
				owed_d    = 2'd2;
				trail_d   = 2'd2;
				pv_d      = {17'b0, b[3:0]};
				lead_emit = eot;
			end else if ((b & utf8sd_pkg::Lead4Mask) == utf8sd_pkg::Lead4Code) begin
				owed_d    = 2'd3;
				trail_d   = 2'd3;
				pv_d      = {18'b0, b[2:0]};
				lead_emit = eot;
			end else begin
				lead_emit = 1'b1;
				owed_d    = 2'd0;
				trail_d   = 2'd0;
				pv_d      = '0;
			end
			if (bytes_owed_q != 2'd0) begin
				n   = lead_emit ? 2'd2 : 2'd1;
				cp1 = lead_cp;
			end else begin
				n   = lead_emit ? 2'd1 : 2'd0;
				cp0 = lead_cp;
			end
		end
		if (eot) begin
			owed_d  = 2'd0;
			trail_d = 2'd0;
			pv_d    = '0;
		end
	end

	always_comb begin
		res.count              = n;
		res.first.code_point   = cp0;
		res.first.last_of_run  = (n == 2'd1);
		res.second.code_point  = cp1;
		res.second.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_owed_q        <= 2'd0;
			sequence_trailing_q <= 2'd0;
			partial_value_q     <= '0;
		end else if (fire) begin
			bytes_owed_q        <= owed_d;
			sequence_trailing_q <= trail_d;
			partial_value_q     <= pv_d;
		end
	end

endmodule

/* rtl/core/utf8sd_outq.sv */
// four-entry result queue, takes up to two results a cycle, gives one while cp_stall is low
// depends on utf8sd_pkg
module utf8sd_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  utf8sd_pkg::dec_res_t  res,
	output logic                  room,
	output logic                  cp_valid,
	input  logic                  cp_stall,
	output utf8sd_pkg::cp_beat_t  cp_beat
);

	utf8sd_pkg::cp_beat_t mem_q [4];
	logic [1:0]           wr_q;
	logic [1:0]           rd_q;
	logic [2:0]           count_q;
	logic                 pop;
	logic [1:0]           n_push;
	logic [1:0]           wr_next;

	assign n_push   = push ? res.count : 2'd0;
	assign pop      = cp_valid && !cp_stall;
	assign cp_valid = count_q != 3'd0;
	assign cp_beat  = mem_q[rd_q];
	assign room     = count_q <= 3'd2;
	assign wr_next  = wr_q + 2'd1;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_q] <= res.first;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_next] <= res.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 3'd0;
		end else begin
			wr_q    <= wr_q + n_push;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + {1'b0, n_push} - {2'b0, pop};
		end
	end

endmodule

/* rtl/core/utf8_byte_stream_decoder_top.sv */
// utf-8 byte stream decoder: one byte in, zero to two code points out
// path: an accepted byte is registered in beat_s1, decoded, then written into the result queue
// throughput: one byte per cycle while each byte gives at most one result and cp_stall is low;
// a byte that gives two results sends both through the single output port, one after the other
// reset: arst_n clears the sequence state, the input valid flag and the result queue
// depends on utf8sd_pkg, utf8sd_decode, utf8sd_outq
module utf8_byte_stream_decoder_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  utf8sd_pkg::byte_beat_t byte_beat,
	output logic                  cp_valid,
	input  logic                  cp_stall,
	output utf8sd_pkg::cp_beat_t  cp_beat
);

	utf8sd_pkg::byte_beat_t beat_s1;
	logic                   valid_s1;
	logic                   room;
	logic                   fire;
	logic                   accept;
	utf8sd_pkg::dec_res_t   res;

	assign fire       = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1 <= byte_beat;
		end
	end

	utf8sd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.beat   (beat_s1),
		.res    (res)
	);

	utf8sd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire),
		.res      (res),
		.room     (room),
		.cp_valid (cp_valid),
		.cp_stall (cp_stall),
		.cp_beat  (cp_beat)
	);

endmodule

/* tb/sv/utf8_byte_stream_decoder_top_tb.sv */
// testbench for utf8_byte_stream_decoder_top: directed and random utf-8 byte beats,
// code points checked in order against a predictor kept in a small scoreboard class
// depends on utf8sd_pkg and utf8_byte_stream_decoder_top
module utf8_byte_stream_decoder_top_tb;
	import utf8sd_pkg::*;

	localparam int unsigned RandomBytes = 750;
	localparam int unsigned CalmTail    = 100;
	localparam int unsigned CycleLimit  = 200000;

	typedef enum logic [2:0] {
		LeadAscii,
		Lead2,
		Lead3,
		Lead4,
		LeadBad
	} lead_kind_e;

	class utf8_cp_scoreboard;
		cp_beat_t           expected_cps[$];
		logic [1:0]         owed;
		logic [1:0]         trailing;
		logic [CpWidth-1:0] partial;
		int unsigned        errors;
		int unsigned        bytes_noted;
		int unsigned        cps_checked;
		int unsigned        replacements;

		function new();
			owed         = '0;
			trailing     = '0;
			partial      = '0;
			errors       = 0;
			bytes_noted  = 0;
			cps_checked  = 0;
			replacements = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void go_idle();
			owed     = '0;
			trailing = '0;
			partial  = '0;
		endfunction

		function void push_cp(logic [CpWidth-1:0] cp);
			cp_beat_t beat;
			beat.code_point  = cp;
			beat.last_of_run = 1'b0;
			expected_cps.insert(expected_cps.size(), beat);
		endfunction

		function lead_kind_e classify_lead(logic [7:0] b);
			if (!b[7])
				return LeadAscii;
			if ((b & Lead2Mask) == Lead2Code)
				return Lead2;
			if ((b & Lead3Mask) == Lead3Code)
				return Lead3;
			if ((b & Lead4Mask) == Lead4Code)
				return Lead4;
			return LeadBad;
		endfunction

		function logic [CpWidth-1:0] screen_value(logic [CpWidth-1:0] v, logic [1:0] tr);
			logic [CpWidth-1:0] floor_cp;
			floor_cp = (tr == 2'd1) ? Min2Byte : (tr == 2'd2) ? Min3Byte : Min4Byte;
			if (v < floor_cp || (v >= SurrogateLo && v <= SurrogateHi) || v > MaxScalar)
				return Replacement;
			return v;
		endfunction

		// flag the final code point caused by this beat, and go idle at end of text
		function void close_run(int unsigned base, logic eot);
			cp_beat_t    tail;
			int unsigned last_idx;
			if (eot)
				go_idle();
			if (expected_cps.size() > base) begin
				last_idx = expected_cps.size() - 1;
				tail = expected_cps[last_idx];
				tail.last_of_run = 1'b1;
				expected_cps[last_idx] = tail;
			end
		endfunction

		function void note_byte(byte_beat_t bt);
			logic [7:0]  b;
			int unsigned base;
			b    = bt.text_byte;
			base = expected_cps.size();
			bytes_noted++;
			if (owed != 2'd0) begin
				if ((b & ContMask) == ContCode) begin
					partial = {partial[CpWidth-7:0], b[5:0]};
					owed    = owed - 2'd1;
					if (owed == 2'd0) begin
						push_cp(screen_value(partial, trailing));
						go_idle();
					end else if (bt.end_of_text) begin
						push_cp(Replacement);
						go_idle();
					end
					close_run(base, bt.end_of_text);
					return;
				end
				// cut sequence, byte falls through as a new lead
				push_cp(Replacement);
				go_idle();
			end
			case (classify_lead(b))
				LeadAscii: push_cp({{(CpWidth-8){1'b0}}, b});
				LeadBad:   push_cp(Replacement);
				default: begin
					case (classify_lead(b))
						Lead2: begin
							trailing = 2'd1;
							partial  = {{(CpWidth-5){1'b0}}, b[4:0]};
						end
						Lead3: begin
							trailing = 2'd2;
							partial  = {{(CpWidth-4){1'b0}}, b[3:0]};
						end
						default: begin
							trailing = 2'd3;
							partial  = {{(CpWidth-3){1'b0}}, b[2:0]};
						end
					endcase
					owed = trailing;
					if (bt.end_of_text)
						push_cp(Replacement);
				end
			endcase
			close_run(base, bt.end_of_text);
		endfunction

		task check_cp(cp_beat_t got);
			cp_beat_t want;
			cps_checked++;
			if (got.code_point == Replacement)
				replacements++;
			if (expected_cps.size() == 0) begin
				report($sformatf("unexpected code point %h last %b",
					got.code_point, got.last_of_run));
				return;
			end
			want = expected_cps.pop_front();
			if (got.code_point !== want.code_point)
				report($sformatf("code point %h, want %h", got.code_point, want.code_point));
			if (got.last_of_run !== want.last_of_run)
				report($sformatf("last_of_run %b on %h, want %b",
					got.last_of_run, got.code_point, want.last_of_run));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	byte_beat_t byte_beat;
	logic       cp_valid;
	logic       cp_stall;
	cp_beat_t   cp_beat;

	utf8_cp_scoreboard sb;
	bit                idle_on;
	int unsigned       bytes_sent;
	int unsigned       cycles;

	utf8_byte_stream_decoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_beat (byte_beat),
		.cp_valid  (cp_valid),
		.cp_stall  (cp_stall),
		.cp_beat   (cp_beat)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d code points outstanding",
				cycles, sb.expected_cps.size());
			$display("simulation failed");
			$finish;
		end
	end

	// output side
	always @(posedge clk) begin
		if (arst_n && cp_valid && !cp_stall)
			sb.check_cp(cp_beat);
	end

	initial begin
		cp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				cp_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			cp_stall <= 1'b0;
		end
	end

	// called at a falling edge, returns at the falling edge after the beat is taken
	task send_byte(logic [7:0] b, logic eot);
		byte_beat_t bt;
		bt.text_byte   = b;
		bt.end_of_text = eot;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_beat  <= bt;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		sb.note_byte(bt);
		bytes_sent++;
		@(negedge clk);
	endtask

	// one character, mostly well formed, sometimes truncated or preceded by noise
	task send_random_char();
		logic [7:0]         seq [4];
		logic [CpWidth-1:0] cp;
		int unsigned        len;
		int unsigned        keep;
		len = $urandom_range(1, 4);
		cp  = CpWidth'($urandom);
		case (len)
			1: seq[0] = {1'b0, cp[6:0]};
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				if ($urandom_range(0, 1) == 0)
					cp = CpWidth'($urandom_range(32'h10000, 32'h10FFFF));
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		keep = len;
		if (len > 1 && $urandom_range(0, 9) == 0)
			keep = $urandom_range(1, len - 1);
		if ($urandom_range(0, 11) == 0)
			send_byte(8'($urandom), 1'($urandom));
		for (int unsigned i = 0; i < keep; i++)
			send_byte(seq[i], ($urandom_range(0, 29) == 0) ||
				(i == keep - 1 && $urandom_range(0, 9) == 0));
	endtask

	initial begin
		sb         = new();
		idle_on    = 1'b1;
		bytes_sent = 0;
		cycles     = 0;
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_beat  = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ascii extremes, smallest two-byte value, overlong, surrogate
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hC2, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hC0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hED, 1'b0);
		send_byte(8'hA0, 1'b0);
		send_byte(8'h80, 1'b0);
		// above max scalar, then the max scalar itself
		send_byte(8'hF4, 1'b0);
		send_byte(8'h90, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hF4, 1'b0);
		send_byte(8'h8F, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		// stray continuation, bad lead
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		// cut by ascii, cut by end of text
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b1);
		send_byte(8'hF0, 1'b1);
		// cut by a new lead that ends the text
		send_byte(8'hE3, 1'b0);
		send_byte(8'hC3, 1'b1);

		while (bytes_sent < RandomBytes) begin
			idle_on = (bytes_sent + CalmTail < RandomBytes);
			send_random_char();
		end
		idle_on = 1'b0;
		byte_valid <= 1'b0;

		while (sb.expected_cps.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d bytes, checked %0d code points, %0d of them replacements",
			sb.bytes_noted, sb.cps_checked, sb.replacements);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
